// ===== hw/rtl/source_token_scanner_defines.svh =====
// assertion macros shared by the scanner rtl
`ifndef SOURCE_TOKEN_SCANNER_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define STS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("scanner check failed");

// next-cycle implication checked outside reset
`define STS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("scanner check failed");

`endif

// ===== hw/rtl/sts_pkg.sv =====
// package: token codes, phases, keyword and operator tables
package sts_pkg;

    localparam int unsigned POS_WIDTH_DEFAULT = 16;
    localparam int unsigned KIND_W = 6;
    localparam int unsigned OUT_W = 16;
    localparam int unsigned NKW = 13;
    localparam int unsigned MAXRES = 3;
    localparam int unsigned CNT_W = 2;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_WORD    = 3'd1,
        PH_NUM     = 3'd2,
        PH_POINT   = 3'd3,
        PH_STRING  = 3'd4,
        PH_COMMENT = 3'd5,
        PH_OP      = 3'd6,
        PH_DRAIN   = 3'd7
    } phase_t;

    localparam logic [KIND_W-1:0] K_END = 6'd0;
    localparam logic [KIND_W-1:0] K_ERROR = 6'd1;
    localparam logic [KIND_W-1:0] K_IDENT = 6'd2;
    localparam logic [KIND_W-1:0] K_STRING = 6'd3;
    localparam logic [KIND_W-1:0] K_INT = 6'd4;
    localparam logic [KIND_W-1:0] K_REAL = 6'd5;
    localparam logic [KIND_W-1:0] K_KEYWORD0 = 6'd6;
    localparam logic [KIND_W-1:0] K_SLASH_SLASH = 6'd42;
    localparam logic [KIND_W-1:0] K_DOT = 6'd46;

    // one result token before output truncation
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [31:0]       start;
        logic [31:0]       len;
        logic [31:0]       line;
    } token_t;

    // operator lookup result
    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
        logic [1:0]        npairs;
        logic [7:0]        sec0;
        logic [7:0]        sec1;
    } op_info_t;

    function automatic op_info_t find_op(input logic [7:0] b);
        op_info_t r;
        r = '{hit: 1'b1, kind: '0, npairs: 2'd0, sec0: 8'd0, sec1: 8'd0};
        case (b)
            "+": r = '{1'b1, 6'd19, 2'd2, "+", "="};
            "-": r = '{1'b1, 6'd22, 2'd2, "-", "="};
            "=": r = '{1'b1, 6'd25, 2'd1, "=", 8'd0};
            "!": r = '{1'b1, 6'd27, 2'd1, "=", 8'd0};
            ">": r = '{1'b1, 6'd29, 2'd1, "=", 8'd0};
            "<": r = '{1'b1, 6'd31, 2'd1, "=", 8'd0};
            "&": r = '{1'b1, 6'd33, 2'd2, "&", "="};
            "|": r = '{1'b1, 6'd36, 2'd2, "|", "="};
            "*": r = '{1'b1, 6'd39, 2'd1, "=", 8'd0};
            "/": r = '{1'b1, 6'd41, 2'd2, "/", "="};
            ":": r.kind = 6'd44;
            ";": r.kind = 6'd45;
            ".": r.kind = 6'd46;
            ",": r.kind = 6'd47;
            "(": r.kind = 6'd48;
            ")": r.kind = 6'd49;
            "{": r.kind = 6'd50;
            "}": r.kind = 6'd51;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // keyword character at a given offset, zero past its end
    function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned n);
        logic [47:0] t;
        case (k)
            0: t = {"var", 24'd0};
            1: t = {"true", 16'd0};
            2: t = {"this", 16'd0};
            3: t = {"fn", 32'd0};
            4: t = {"false", 8'd0};
            5: t = {"for", 24'd0};
            6: t = {"if", 32'd0};
            7: t = {"else", 16'd0};
            8: t = {"while", 8'd0};
            9: t = {"null", 16'd0};
            10: t = {"super", 8'd0};
            11: t = {"class", 8'd0};
            default: t = "return";
        endcase
        return (n < 6) ? t[47-8*n -: 8] : 8'd0;
    endfunction

    function automatic logic [2:0] kw_len(input int unsigned k);
        case (k)
            0, 5: return 3'd3;
            3, 6: return 3'd2;
            4, 8, 10, 11: return 3'd5;
            12: return 3'd6;
            default: return 3'd4;
        endcase
    endfunction

    function automatic logic is_dec_char(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_ident(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || is_dec_char(b) || b == "_";
    endfunction

endpackage

// ===== hw/rtl/source_token_scanner.sv =====
// top level: scanner state, token buffer and output port
// a byte's first token appears on the outputs in the cycle after it is taken
// throughput: one byte per cycle while out_ready is high and a byte yields
// at most one token; with two or three, input waits for the last to leave
// reset: rst_n clears the scanner to idle and empties the token buffer
module source_token_scanner
    import sts_pkg::*;
#(
    parameter int unsigned POSITION_WIDTH = POS_WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          ch,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KIND_W-1:0]   token_kind,
    output logic [OUT_W-1:0]    start_res,
    output logic [OUT_W-1:0]    length,
    output logic [OUT_W-1:0]    line,
    output logic                run_end
);

`include "source_token_scanner_defines.svh"

    phase_t                    phase_reg, phase_next;
    logic [7:0]                held_reg, held_next;
    logic [POSITION_WIDTH-1:0] tstart_reg, tstart_next;
    logic [POSITION_WIDTH-1:0] tlen_reg, tlen_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [POSITION_WIDTH-1:0] line_reg, line_next;
    logic [NKW-1:0]            kw_reg, kw_next;
    logic                      seen_reg, seen_next;
    logic                      bs_reg, bs_next;

    token_t [MAXRES-1:0]       tok;
    logic [CNT_W-1:0]          tok_cnt;

    token_t [MAXRES-1:0]       buf_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic                      in_xfer;
    logic                      out_xfer;
    logic                      last_one;

    sts_core #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .ch         (ch),
        .last       (last),
        .phase      (phase_reg),
        .held       (held_reg),
        .tstart     (tstart_reg),
        .tlen       (tlen_reg),
        .pos        (pos_reg),
        .line_cnt   (line_reg),
        .kw_alive   (kw_reg),
        .seen_pt    (seen_reg),
        .after_bs   (bs_reg),
        .phase_next (phase_next),
        .held_next  (held_next),
        .tstart_next(tstart_next),
        .tlen_next  (tlen_next),
        .pos_next   (pos_next),
        .line_next  (line_next),
        .kw_next    (kw_next),
        .seen_next  (seen_next),
        .bs_next    (bs_next),
        .tok        (tok),
        .tok_cnt    (tok_cnt)
    );

    // buffer is free when empty or its final token leaves this cycle
    assign last_one = (idx_reg + 1'b1 == cnt_reg);
    assign out_valid = (cnt_reg != '0);
    assign out_xfer = out_valid && out_ready;
    assign in_ready = !out_valid || (out_ready && last_one);
    assign in_xfer = in_valid && in_ready;

    assign token_kind = buf_reg[idx_reg].kind;
    assign start_res = buf_reg[idx_reg].start[OUT_W-1:0];
    assign length = buf_reg[idx_reg].len[OUT_W-1:0];
    assign line = buf_reg[idx_reg].line[OUT_W-1:0];
    assign run_end = last_one;

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg <= '0;
            tstart_reg <= '0;
            tlen_reg <= '0;
            pos_reg <= '0;
            line_reg <= '0;
            kw_reg <= '1;
            seen_reg <= 1'b0;
            bs_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            phase_reg <= phase_next;
            held_reg <= held_next;
            tstart_reg <= tstart_next;
            tlen_reg <= tlen_next;
            pos_reg <= pos_next;
            line_reg <= line_next;
            kw_reg <= kw_next;
            seen_reg <= seen_next;
            bs_reg <= bs_next;
        end
    end

    // token buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (in_xfer)
        begin
            cnt_reg <= tok_cnt;
            idx_reg <= '0;
        end
        else if (out_xfer)
        begin
            if (last_one)
                cnt_reg <= '0;
            idx_reg <= last_one ? '0 : idx_reg + 1'b1;
        end
    end

    // token buffer payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            buf_reg <= tok;
        end
    end

    `STS_ASSERT_IMP(a_idx_in_range, clk, rst_n, out_valid, idx_reg < cnt_reg)
    `STS_ASSERT_IMP(a_no_take_while_busy, clk, rst_n, out_valid && !last_one, !in_ready)
    `STS_ASSERT_NEXT(a_drain_silent, clk, rst_n, in_xfer && phase_reg == PH_DRAIN, !out_valid)

endmodule

// ===== hw/rtl/sts_core.sv =====
// one-byte scanning step: next state and up to three tokens
module sts_core
    import sts_pkg::*;
#(
    parameter int unsigned POSITION_WIDTH = POS_WIDTH_DEFAULT
) (
    input  logic [7:0]                ch,
    input  logic                      last,
    input  phase_t                    phase,
    input  logic [7:0]                held,
    input  logic [POSITION_WIDTH-1:0] tstart,
    input  logic [POSITION_WIDTH-1:0] tlen,
    input  logic [POSITION_WIDTH-1:0] pos,
    input  logic [POSITION_WIDTH-1:0] line_cnt,
    input  logic [NKW-1:0]            kw_alive,
    input  logic                      seen_pt,
    input  logic                      after_bs,
    output phase_t                    phase_next,
    output logic [7:0]                held_next,
    output logic [POSITION_WIDTH-1:0] tstart_next,
    output logic [POSITION_WIDTH-1:0] tlen_next,
    output logic [POSITION_WIDTH-1:0] pos_next,
    output logic [POSITION_WIDTH-1:0] line_next,
    output logic [NKW-1:0]            kw_next,
    output logic                      seen_next,
    output logic                      bs_next,
    output token_t [MAXRES-1:0]       tok,
    output logic [CNT_W-1:0]          tok_cnt
);

    localparam logic [POSITION_WIDTH-1:0] PMAX = '1;

    function automatic logic [POSITION_WIDTH-1:0] sat_inc(input logic [POSITION_WIDTH-1:0] v);
        return (v == PMAX) ? PMAX : v + 1'b1;
    endfunction

    function automatic logic [POSITION_WIDTH-1:0] sat_add(
        input logic [POSITION_WIDTH-1:0] a, input logic [POSITION_WIDTH-1:0] b);
        logic [POSITION_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POSITION_WIDTH] ? PMAX : s[POSITION_WIDTH-1:0];
    endfunction

    // keyword code for a finished word, lowest matching keyword wins
    function automatic logic [KIND_W-1:0] word_code(
        input logic [NKW-1:0] alive, input logic [POSITION_WIDTH-1:0] len);
        logic [KIND_W-1:0] k;
        k = K_IDENT;
        for (int i = NKW - 1; i >= 0; i--)
        begin
            if (alive[i] && {{(POSITION_WIDTH-3){1'b0}}, kw_len(i)} == len)
                k = K_KEYWORD0 + KIND_W'(i);
        end
        return k;
    endfunction

    // combinational scan of one byte
    always_comb
    begin
        phase_t                    ph;
        logic [CNT_W-1:0]          n;
        logic                      fresh;
        logic                      flush;
        logic                      term;
        op_info_t                  oh;
        op_info_t                  ob;
        op_info_t                  oh2;
        logic [KIND_W-1:0]         wk;
        logic [KIND_W-1:0]         wk2;
        logic [NKW-1:0]            al;
        logic [POSITION_WIDTH-1:0] lc;
        logic [POSITION_WIDTH-1:0] endpos;
        ph = phase;
        n = '0;
        fresh = 1'b0;
        flush = 1'b0;
        lc = line_cnt;
        endpos = '0;
        held_next = held;
        tstart_next = tstart;
        tlen_next = tlen;
        kw_next = kw_alive;
        seen_next = seen_pt;
        bs_next = after_bs;
        pos_next = pos;
        tok = '0;
        term = (ch == 8'h00) || (ch == 8'hFF);
        oh = find_op(held);
        ob = find_op(ch);
        wk = word_code(kw_alive, tlen);
        al = '0;
        for (int i = 0; i < NKW; i++)
        begin
            if (kw_alive[i] && tlen < {{(POSITION_WIDTH-3){1'b0}}, kw_len(i)}
                && kw_char(i, 32'(tlen[2:0])) == ch)
                al[i] = 1'b1;
        end

        // continue the pending token or decide to flush it
        if (phase != PH_DRAIN && !term)
        begin
            case (phase)
                PH_WORD:
                    if (is_ident(ch))
                    begin
                        kw_next = al;
                        tlen_next = sat_inc(tlen);
                    end
                    else
                        flush = 1'b1;
                PH_NUM:
                    if (is_dec_char(ch))
                        tlen_next = sat_inc(tlen);
                    else if (ch == ".")
                        ph = PH_POINT;
                    else
                        flush = 1'b1;
                PH_POINT:
                    if (is_dec_char(ch))
                    begin
                        seen_next = 1'b1;
                        tlen_next = sat_add(tlen, POSITION_WIDTH'(2));
                        ph = PH_NUM;
                    end
                    else
                        flush = 1'b1;
                PH_STRING:
                begin
                    tlen_next = sat_inc(tlen);
                    if (ch == "\"" && !after_bs)
                    begin
                        tok[0] = '{K_STRING, 32'(tstart), 32'(sat_inc(tlen)), 32'(line_cnt)};
                        n = 2'd1;
                        ph = PH_IDLE;
                    end
                    else
                        bs_next = (ch == "\\");
                end
                PH_COMMENT:
                    if (ch == "\n")
                    begin
                        lc = sat_inc(line_cnt);
                        ph = PH_IDLE;
                    end
                PH_OP:
                    if (oh.hit && oh.npairs >= 2'd1 && oh.sec0 == ch)
                    begin
                        tok[0] = '{oh.kind + 6'd1, 32'(tstart), 32'd2, 32'(line_cnt)};
                        n = 2'd1;
                        ph = (oh.kind + 6'd1 == K_SLASH_SLASH) ? PH_COMMENT : PH_IDLE;
                    end
                    else if (oh.hit && oh.npairs == 2'd2 && oh.sec1 == ch)
                    begin
                        tok[0] = '{oh.kind + 6'd2, 32'(tstart), 32'd2, 32'(line_cnt)};
                        n = 2'd1;
                        ph = PH_IDLE;
                    end
                    else
                        flush = 1'b1;
                default:
                    fresh = 1'b1;
            endcase
        end
        else if (phase != PH_DRAIN)
            flush = 1'b1;
        if (flush && !term)
            fresh = 1'b1;

        // flush of the pending token
        if (flush)
        begin
            case (phase)
                PH_WORD:
                begin
                    tok[0] = '{wk, 32'(tstart), 32'(tlen), 32'(line_cnt)};
                    n = 2'd1;
                end
                PH_NUM:
                begin
                    tok[0] = '{seen_pt ? K_REAL : K_INT, 32'(tstart), 32'(tlen), 32'(line_cnt)};
                    n = 2'd1;
                end
                PH_POINT:
                begin
                    tok[0] = '{seen_pt ? K_REAL : K_INT, 32'(tstart), 32'(tlen), 32'(line_cnt)};
                    tok[1] = '{K_DOT, 32'(sat_add(tstart, tlen)), 32'd1, 32'(line_cnt)};
                    n = 2'd2;
                end
                PH_STRING:
                begin
                    tok[0] = '{K_ERROR, 32'(tstart), 32'(tlen), 32'(line_cnt)};
                    n = 2'd1;
                end
                PH_OP:
                begin
                    tok[0] = '{oh.kind, 32'(tstart), 32'd1, 32'(line_cnt)};
                    n = {1'b0, oh.hit};
                end
                default:
                    n = '0;
            endcase
            ph = PH_IDLE;
        end

        // start a new token from this byte
        if (fresh)
        begin
            if (ch == " " || ch == "\t" || ch == "\r")
                ph = PH_IDLE;
            else if (ch == "\n")
                lc = sat_inc(line_cnt);
            else if (ch == "\"")
            begin
                ph = PH_STRING;
                tstart_next = pos;
                tlen_next = POSITION_WIDTH'(1);
                bs_next = 1'b0;
            end
            else if (ob.hit && ob.npairs != 2'd0)
            begin
                ph = PH_OP;
                held_next = ch;
                tstart_next = pos;
            end
            else if (ob.hit)
            begin
                tok[n] = '{ob.kind, 32'(pos), 32'd1, 32'(lc)};
                n = n + 1'b1;
            end
            else if (is_dec_char(ch))
            begin
                ph = PH_NUM;
                tstart_next = pos;
                tlen_next = POSITION_WIDTH'(1);
                seen_next = 1'b0;
            end
            else if (is_ident(ch))
            begin
                ph = PH_WORD;
                tstart_next = pos;
                tlen_next = POSITION_WIDTH'(1);
                for (int i = 0; i < NKW; i++)
                    kw_next[i] = (kw_char(i, 0) == ch);
            end
            else
            begin
                tok[n] = '{K_ERROR, 32'(pos), 32'd1, 32'(lc)};
                n = n + 1'b1;
            end
        end

        // a last byte also completes the token it leaves open
        wk2 = word_code(kw_next, tlen_next);
        oh2 = find_op(held_next);
        if (last && !term && phase != PH_DRAIN)
        begin
            case (ph)
                PH_WORD:
                    if (n != 2'd3)
                    begin
                        tok[n] = '{wk2, 32'(tstart_next), 32'(tlen_next), 32'(lc)};
                        n = n + 1'b1;
                    end
                PH_NUM:
                    if (n != 2'd3)
                    begin
                        tok[n] = '{seen_next ? K_REAL : K_INT, 32'(tstart_next),
                                   32'(tlen_next), 32'(lc)};
                        n = n + 1'b1;
                    end
                PH_POINT:
                begin
                    if (n != 2'd3)
                    begin
                        tok[n] = '{seen_next ? K_REAL : K_INT, 32'(tstart_next),
                                   32'(tlen_next), 32'(lc)};
                        n = n + 1'b1;
                    end
                    if (n != 2'd3)
                    begin
                        tok[n] = '{K_DOT, 32'(sat_add(tstart_next, tlen_next)), 32'd1,
                                   32'(lc)};
                        n = n + 1'b1;
                    end
                end
                PH_STRING:
                    if (n != 2'd3)
                    begin
                        tok[n] = '{K_ERROR, 32'(tstart_next), 32'(tlen_next), 32'(lc)};
                        n = n + 1'b1;
                    end
                PH_OP:
                    if (oh2.hit && n != 2'd3)
                    begin
                        tok[n] = '{oh2.kind, 32'(tstart_next), 32'd1, 32'(lc)};
                        n = n + 1'b1;
                    end
                default:
                    ;
            endcase
        end

        line_next = lc;
        phase_next = ph;
        if (phase != PH_DRAIN && !term)
            pos_next = sat_inc(pos);

        // end of text: end token, cleared state, idle or drain phase
        if (phase == PH_DRAIN)
        begin
            phase_next = last ? PH_IDLE : PH_DRAIN;
        end
        else if (term || last)
        begin
            endpos = term ? ((pos != '0) ? pos - 1'b1 : '0) : pos;
            if (n != 2'd3)
            begin
                tok[n] = '{K_END, 32'(endpos), 32'd1, 32'(lc)};
                n = n + 1'b1;
            end
            phase_next = (term && !last) ? PH_DRAIN : PH_IDLE;
            held_next = '0;
            tstart_next = '0;
            tlen_next = '0;
            pos_next = '0;
            line_next = '0;
            kw_next = '1;
            seen_next = 1'b0;
            bs_next = 1'b0;
        end
        tok_cnt = n;
    end

endmodule

// ===== dv/source_token_scanner_test.sv =====
// testbench for the source token scanner: stimulus, token predictor and checker
`timescale 1ns / 100ps

module source_token_scanner_test;
    import sts_pkg::*;

    // operator base codes, two-byte forms follow their base
    localparam logic [5:0] K_PLUS = 6'd19;
    localparam logic [5:0] K_MINUS = 6'd22;
    localparam logic [5:0] K_ASSIGN = 6'd25;
    localparam logic [5:0] K_BANG = 6'd27;
    localparam logic [5:0] K_GREATER = 6'd29;
    localparam logic [5:0] K_LESS = 6'd31;
    localparam logic [5:0] K_AMP = 6'd33;
    localparam logic [5:0] K_PIPE = 6'd36;
    localparam logic [5:0] K_STAR = 6'd39;
    localparam logic [5:0] K_SLASH = 6'd41;
    localparam logic [5:0] K_COLON = 6'd44;
    localparam logic [5:0] K_SEMI = 6'd45;
    localparam logic [5:0] K_COMMA = 6'd47;
    localparam logic [5:0] K_LPAREN = 6'd48;
    localparam logic [5:0] K_RPAREN = 6'd49;
    localparam logic [5:0] K_LBRACE = 6'd50;
    localparam logic [5:0] K_RBRACE = 6'd51;
    localparam logic [5:0] K_NONE = 6'd0;
    localparam logic [7:0] TERM_ZERO = 8'h00;
    localparam logic [7:0] TERM_ONES = 8'hFF;
    localparam int NUM_ITEMS = 400;

    typedef struct {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        run_end;
    } token_rec_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } byte_rec_t;

    typedef struct {
        logic [7:0]  ch;
        logic        last;
        logic        typed;
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ch;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  token_kind;
    logic [15:0] start_res;
    logic [15:0] length;
    logic [15:0] line;
    logic        run_end;

    source_token_scanner dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .token_kind (token_kind),
        .start_res  (start_res),
        .length     (length),
        .line       (line),
        .run_end    (run_end)
    );

    token_rec_t expected_tokens[$];
    byte_rec_t  source_bytes[$];
    int         error_count;
    int         bytes_taken;
    bit         feed_done;

    // predictor copy of the scanner state
    phase_t      sc_phase;
    logic [7:0]  sc_held;
    logic [15:0] sc_start;
    logic [15:0] sc_len;
    logic [15:0] sc_pos;
    logic [15:0] sc_lines;
    logic        sc_point;
    logic        sc_escape;
    string       sc_word;
    int          step_count;

    string keywords[13] = '{"var", "true", "this", "fn", "false", "for", "if",
                            "else", "while", "null", "super", "class", "return"};

    // clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [5:0] op_base(input logic [7:0] b);
        case (b)
            "+": return K_PLUS;
            "-": return K_MINUS;
            "=": return K_ASSIGN;
            "!": return K_BANG;
            ">": return K_GREATER;
            "<": return K_LESS;
            "&": return K_AMP;
            "|": return K_PIPE;
            "*": return K_STAR;
            "/": return K_SLASH;
            ":": return K_COLON;
            ";": return K_SEMI;
            ".": return K_DOT;
            ",": return K_COMMA;
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            default: return K_NONE;
        endcase
    endfunction

    // second byte of the k-th two-byte form, zero where none
    function automatic logic [7:0] op_second(input logic [7:0] b, input int k);
        case (b)
            "+": return (k == 0) ? "+" : "=";
            "-": return (k == 0) ? "-" : "=";
            "&": return (k == 0) ? "&" : "=";
            "|": return (k == 0) ? "|" : "=";
            "/": return (k == 0) ? "/" : "=";
            "=", "!", ">", "<", "*": return (k == 0) ? "=" : 8'd0;
            default: return 8'd0;
        endcase
    endfunction

    function automatic bit is_dig(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_word(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || is_dig(b) || b == "_";
    endfunction

    task scan_clear();
        sc_phase = PH_IDLE;
        sc_held = 8'd0;
        sc_start = '0;
        sc_len = '0;
        sc_pos = '0;
        sc_lines = '0;
        sc_point = 1'b0;
        sc_escape = 1'b0;
        sc_word = "";
    endtask

    task push_token(input logic [5:0] kind, input logic [15:0] start, input logic [15:0] len);
        token_rec_t t;
        if (step_count < MAXRES)
        begin
            t = '{kind, start, len, sc_lines, 1'b0};
            expected_tokens.push_back(t);
            step_count++;
        end
    endtask

    function automatic logic [5:0] word_code();
        for (int i = 0; i < 13; i++)
            if (sc_word == keywords[i])
                return K_KEYWORD0 + 6'(i);
        return K_IDENT;
    endfunction

    // complete whatever token is open
    task close_pending();
        case (sc_phase)
            PH_WORD: push_token(word_code(), sc_start, sc_len);
            PH_NUM: push_token(sc_point ? K_REAL : K_INT, sc_start, sc_len);
            PH_POINT:
            begin
                push_token(sc_point ? K_REAL : K_INT, sc_start, sc_len);
                push_token(K_DOT, sat_add16(sc_start, sc_len), 16'd1);
            end
            PH_STRING: push_token(K_ERROR, sc_start, sc_len);
            PH_OP: push_token(op_base(sc_held), sc_start, 16'd1);
            default: ;
        endcase
        sc_phase = PH_IDLE;
    endtask

    task begin_token(input logic [7:0] b, input logic [15:0] p);
        logic [5:0] base;
        base = op_base(b);
        if (b == " " || b == "\t" || b == "\r")
            return;
        if (b == "\n")
        begin
            sc_lines = sat_inc16(sc_lines);
            return;
        end
        if (b == "\"")
        begin
            sc_phase = PH_STRING;
            sc_start = p;
            sc_len = 16'd1;
            sc_escape = 1'b0;
            return;
        end
        if (base != K_NONE)
        begin
            if (op_second(b, 0) != 8'd0)
            begin
                sc_phase = PH_OP;
                sc_held = b;
                sc_start = p;
            end
            else
                push_token(base, p, 16'd1);
            return;
        end
        if (is_dig(b))
        begin
            sc_phase = PH_NUM;
            sc_start = p;
            sc_len = 16'd1;
            sc_point = 1'b0;
            return;
        end
        if (is_word(b))
        begin
            sc_phase = PH_WORD;
            sc_start = p;
            sc_len = 16'd1;
            sc_word = "";
            sc_word = {sc_word, string'(b)};
            return;
        end
        push_token(K_ERROR, p, 16'd1);
    endtask

    task advance_byte(input logic [7:0] b, input logic [15:0] p);
        logic [5:0] kind;
        case (sc_phase)
            PH_WORD:
            begin
                if (is_word(b))
                begin
                    if (sc_word.len() < 7)
                        sc_word = {sc_word, string'(b)};
                    sc_len = sat_inc16(sc_len);
                    return;
                end
                close_pending();
            end
            PH_NUM:
            begin
                if (is_dig(b))
                begin
                    sc_len = sat_inc16(sc_len);
                    return;
                end
                if (b == ".")
                begin
                    sc_phase = PH_POINT;
                    return;
                end
                close_pending();
            end
            PH_POINT:
            begin
                if (is_dig(b))
                begin
                    sc_point = 1'b1;
                    sc_len = sat_add16(sc_len, 16'd2);
                    sc_phase = PH_NUM;
                    return;
                end
                close_pending();
            end
            PH_STRING:
            begin
                sc_len = sat_inc16(sc_len);
                if (b == "\"" && !sc_escape)
                begin
                    push_token(K_STRING, sc_start, sc_len);
                    sc_phase = PH_IDLE;
                end
                else
                    sc_escape = (b == "\\");
                return;
            end
            PH_COMMENT:
            begin
                if (b == "\n")
                begin
                    sc_lines = sat_inc16(sc_lines);
                    sc_phase = PH_IDLE;
                end
                return;
            end
            PH_OP:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    if (op_second(sc_held, k) != 8'd0 && op_second(sc_held, k) == b)
                    begin
                        kind = op_base(sc_held) + 6'd1 + 6'(k);
                        push_token(kind, sc_start, 16'd2);
                        sc_phase = (kind == K_SLASH_SLASH) ? PH_COMMENT : PH_IDLE;
                        return;
                    end
                end
                close_pending();
            end
            default: ;
        endcase
        begin_token(b, p);
    endtask

    // expected tokens caused by one accepted byte
    task predict_tokens(input logic [7:0] b, input logic lst);
        logic [15:0] p;
        p = sc_pos;
        step_count = 0;
        if (sc_phase == PH_DRAIN)
        begin
            if (lst)
                scan_clear();
            return;
        end
        if (b == TERM_ZERO || b == TERM_ONES)
        begin
            close_pending();
            push_token(K_END, (p > 0) ? p - 16'd1 : 16'd0, 16'd1);
            scan_clear();
            if (!lst)
                sc_phase = PH_DRAIN;
        end
        else
        begin
            advance_byte(b, p);
            sc_pos = sat_inc16(p);
            if (lst)
            begin
                close_pending();
                push_token(K_END, p, 16'd1);
                scan_clear();
            end
        end
        if (step_count > 0)
            expected_tokens[$].run_end = 1'b1;
    endtask

    task report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // random source text generation
    task add_byte(input logic [7:0] b);
        source_bytes.push_back('{b, 1'b0});
    endtask

    task add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task add_random_token();
        string ops;
        int n;
        ops = "+-=!><&|*/:;.,(){}";
        case ($urandom_range(0, 11))
            0, 1:
            begin
                n = $urandom_range(1, 8);
                add_byte((($urandom_range(0, 3) == 0)) ? "_" : 8'("a" + $urandom_range(0, 25)));
                for (int i = 1; i < n; i++)
                    case ($urandom_range(0, 3))
                        0: add_byte(8'("0" + $urandom_range(0, 9)));
                        1: add_byte(8'("A" + $urandom_range(0, 25)));
                        2: add_byte("_");
                        default: add_byte(8'("a" + $urandom_range(0, 25)));
                    endcase
            end
            2:
            begin
                add_text(keywords[$urandom_range(0, 12)]);
                if ($urandom_range(0, 3) == 0)
                    add_byte(8'("a" + $urandom_range(0, 25)));
            end
            3, 4:
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    add_byte(8'("0" + $urandom_range(0, 9)));
                if ($urandom_range(0, 1))
                begin
                    add_byte(".");
                    if ($urandom_range(0, 2) != 0)
                        add_byte(8'("0" + $urandom_range(0, 9)));
                end
            end
            5:
            begin
                add_byte("\"");
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                    case ($urandom_range(0, 4))
                        0: add_byte("\\");
                        1: add_byte("\n");
                        2: add_byte(8'($urandom_range(1, 254)));
                        default: add_byte(8'("a" + $urandom_range(0, 25)));
                    endcase
                add_byte("\"");
            end
            6, 7:
            begin
                add_byte(ops[$urandom_range(0, ops.len() - 1)]);
                if ($urandom_range(0, 1))
                    add_byte(($urandom_range(0, 1)) ? "=" : ops[$urandom_range(0, 9)]);
            end
            8: add_text("//x y\n");
            9: add_byte(($urandom_range(0, 1)) ? "\n" : " ");
            10: add_byte(($urandom_range(0, 1)) ? "\t" : "\r");
            default: add_byte(8'($urandom_range(1, 254)));
        endcase
        if ($urandom_range(0, 2) == 0)
            add_byte(" ");
    endtask

    task add_random_text();
        int n;
        n = $urandom_range(3, 25);
        for (int i = 0; i < n; i++)
            add_random_token();
        if ($urandom_range(0, 5) == 0)
            add_text("\"ab");
        case ($urandom_range(0, 3))
            0:
            begin
                source_bytes.push_back('{($urandom_range(0, 1)) ? TERM_ZERO : TERM_ONES, 1'b1});
            end
            1:
            begin
                source_bytes.push_back('{($urandom_range(0, 1)) ? TERM_ZERO : TERM_ONES, 1'b0});
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                    add_byte(8'($urandom));
                source_bytes.push_back('{8'($urandom), 1'b1});
            end
            default:
            begin
                add_random_token();
                source_bytes[$].last = 1'b1;
            end
        endcase
    endtask

    dir_row_t directed_rows[] = '{
        '{TERM_ZERO, 1'b1, 1'b1, K_END, 16'd0, 16'd1, 16'd0},
        '{"@", 1'b0, 1'b1, K_ERROR, 16'd0, 16'd1, 16'd0},
        '{8'h80, 1'b0, 1'b1, K_ERROR, 16'd1, 16'd1, 16'd0},
        '{8'hFE, 1'b0, 1'b1, K_ERROR, 16'd2, 16'd1, 16'd0},
        '{"v", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"a", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"r", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"=", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"=", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"1", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{".", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"x", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"\n", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"\"", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"\\", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"\"", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"\"", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"/", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"/", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"q", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"\n", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"+", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"(", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{TERM_ONES, 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"z", 1'b0, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"k", 1'b1, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0},
        '{"9", 1'b1, 1'b0, K_NONE, 16'd0, 16'd0, 16'd0}
    };

    // byte sender: bursts with random gaps
    initial
    begin
        int burst_left;
        int gap;
        int qsize;
        int counted;
        byte_rec_t cur;
        token_rec_t t;
        bit drain_flag;
        rst_n = 1'b0;
        in_valid = 1'b0;
        ch = 8'd0;
        last = 1'b0;
        error_count = 0;
        bytes_taken = 0;
        feed_done = 1'b0;
        scan_clear();
        foreach (directed_rows[i])
            source_bytes.push_back('{directed_rows[i].ch, directed_rows[i].last});
        counted = 0;
        drain_flag = 1'b0;
        while (counted < NUM_ITEMS)
        begin
            qsize = source_bytes.size();
            add_random_text();
            for (int i = qsize; i < source_bytes.size(); i++)
            begin
                if (!drain_flag)
                    counted++;
                if (drain_flag && source_bytes[i].last)
                    drain_flag = 1'b0;
                else if (!source_bytes[i].last &&
                         (source_bytes[i].ch == TERM_ZERO || source_bytes[i].ch == TERM_ONES))
                    drain_flag = 1'b1;
            end
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        burst_left = 0;
        for (int i = 0; i < source_bytes.size(); i++)
        begin
            cur = source_bytes[i];
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
            end
            burst_left--;
            in_valid <= 1'b1;
            ch <= cur.ch;
            last <= cur.last;
            do
                @(posedge clk);
            while (!in_ready);
            qsize = expected_tokens.size();
            predict_tokens(cur.ch, cur.last);
            if (i < directed_rows.size() && directed_rows[i].typed)
            begin
                while (expected_tokens.size() > qsize)
                    void'(expected_tokens.pop_back());
                t = '{directed_rows[i].kind, directed_rows[i].start, directed_rows[i].len,
                      directed_rows[i].line, 1'b1};
                expected_tokens.push_back(t);
            end
            bytes_taken++;
        end
        in_valid <= 1'b0;
        feed_done = 1'b1;
    end

    // token receiver and checker
    initial
    begin
        logic [7:0] stall_mask;
        int cyc;
        bit held_off;
        token_rec_t exp_tok;
        out_ready = 1'b0;
        stall_mask = 8'hFF;
        cyc = 0;
        held_off = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_tokens.size() == 0)
                    report_mismatch("token with nothing expected");
                else
                begin
                    exp_tok = expected_tokens.pop_front();
                    if (token_kind !== exp_tok.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", token_kind, exp_tok.kind));
                    if (start_res !== exp_tok.start)
                        report_mismatch($sformatf("start %0d, want %0d", start_res, exp_tok.start));
                    if (length !== exp_tok.len)
                        report_mismatch($sformatf("length %0d, want %0d", length, exp_tok.len));
                    if (line !== exp_tok.line)
                        report_mismatch($sformatf("line %0d, want %0d", line, exp_tok.line));
                    if (run_end !== exp_tok.run_end)
                        report_mismatch($sformatf("run_end %0b, want %0b", run_end,
                                                  exp_tok.run_end));
                end
            end
            // long hold-off once, so the scanner fills up and stalls input
            if (!held_off && bytes_taken >= 150)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            if (cyc % 16 == 0)
                stall_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
            out_ready <= stall_mask[cyc % 8];
            cyc++;
        end
    end

    // end of run
    initial
    begin
        wait (feed_done);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sts_pkg.sv
hw/rtl/sts_core.sv
hw/rtl/source_token_scanner.sv
dv/source_token_scanner_test.sv
